// ----- hdl/bshp_pkg.sv -----
// shared types and constants for the block size header parser
`default_nettype none

package bshp_pkg;

    localparam int PART_COMPONENTS = 3;
    localparam logic [1:0] PART_LAST = 2'(PART_COMPONENTS - 1);

    localparam int CFG_WIDTH = 4;

    localparam logic REG_PACK_MODE_BIT   = 1'b0;
    localparam logic REG_CRC_PRESENT_BIT = 1'b1;

    typedef enum logic [4:0] {
        PH_CLEN   = 5'd0,
        PH_PLEN   = 5'd1,
        PH_MODE   = 5'd2,
        PH_BLOCKS = 5'd3,
        PH_PINFO  = 5'd4,
        PH_PRAW   = 5'd5,
        PH_PST1   = 5'd6,
        PH_PST2   = 5'd7,
        PH_QRAW   = 5'd8,
        PH_QST1   = 5'd9,
        PH_QST2   = 5'd10,
        PH_SRAW   = 5'd11,
        PH_SST1   = 5'd12,
        PH_SST2   = 5'd13,
        PH_TOTP   = 5'd14,
        PH_TOTQ   = 5'd15,
        PH_TOTS   = 5'd16,
        PH_CRC    = 5'd17,
        PH_IDLE   = 5'd18
    } phase_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       start_header;
    } byte_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [7:0]  block_index;
        logic [1:0]  part_index;
        logic [31:0] field_value;
        logic        header_done;
        logic        status;
    } field_t;

endpackage

`default_nettype wire

// ----- hdl/bshp_parser.sv -----
// byte assembler and header phase sequencer with configuration registers
`default_nettype none

module bshp_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire bshp_pkg::byte_t               byte_in,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [bshp_pkg::CFG_WIDTH-1:0] cfg_data,
    output logic                               res_valid,
    output bshp_pkg::field_t                   res
);

    logic [3:0]        pack_bit_reg;
    logic [3:0]        crc_bit_reg;

    bshp_pkg::phase_t  phase_reg, phase_next;
    logic [31:0]       shift_reg, shift_next;
    logic [2:0]        left_reg, left_next;
    logic [31:0]       expected_reg, expected_next;
    logic [15:0]       mode_reg, mode_next;
    logic [7:0]        blocks_reg, blocks_next;
    logic [7:0]        pinfo_reg, pinfo_next;
    logic [7:0]        blk_reg, blk_next;
    logic [1:0]        part_reg, part_next;
    logic [31:0]       total_reg, total_next;

    bshp_pkg::phase_t  phase_eff;
    bshp_pkg::phase_t  ph_nx;
    bshp_pkg::phase_t  ph_after_blocks;
    bshp_pkg::phase_t  ph_after_p;
    bshp_pkg::phase_t  ph_after_s;
    logic [31:0]       shift_eff;
    logic [2:0]        left_eff;
    logic [7:0]        blk_eff;
    logic [1:0]        part_eff;
    logic [31:0]       v;
    logic [2:0]        left_dec;
    logic [7:0]        blk_inc;
    logic [1:0]        part_after_p;
    logic [31:0]       sum_add;
    logic              v_zero;

    function automatic logic [2:0] bytes_for(bshp_pkg::phase_t ph, logic [7:0] pinfo);
        logic [2:0] n;
        case (ph) inside
            bshp_pkg::PH_MODE:                                     n = 3'd2;
            bshp_pkg::PH_BLOCKS, bshp_pkg::PH_PINFO:               n = 3'd1;
            bshp_pkg::PH_PRAW, bshp_pkg::PH_PST1, bshp_pkg::PH_PST2:
                n = pinfo[0] ? 3'd3 : 3'd2;
            bshp_pkg::PH_QRAW, bshp_pkg::PH_QST1, bshp_pkg::PH_QST2:
                n = pinfo[2] ? 3'd3 : 3'd2;
            bshp_pkg::PH_SRAW, bshp_pkg::PH_SST1, bshp_pkg::PH_SST2:
                n = pinfo[4] ? 3'd3 : 3'd2;
            default:                                               n = 3'd4;
        endcase
        return n;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_bit_reg <= 4'd0;
            crc_bit_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bshp_pkg::REG_PACK_MODE_BIT:   pack_bit_reg <= cfg_data;
                bshp_pkg::REG_CRC_PRESENT_BIT: crc_bit_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= bshp_pkg::PH_CLEN;
            shift_reg    <= '0;
            left_reg     <= 3'd4;
            expected_reg <= '0;
            mode_reg     <= '0;
            blocks_reg   <= '0;
            pinfo_reg    <= '0;
            blk_reg      <= '0;
            part_reg     <= '0;
            total_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            left_reg     <= left_next;
            expected_reg <= expected_next;
            mode_reg     <= mode_next;
            blocks_reg   <= blocks_next;
            pinfo_reg    <= pinfo_next;
            blk_reg      <= blk_next;
            part_reg     <= part_next;
            total_reg    <= total_next;
        end
    end

    always_comb
    begin
        phase_eff = phase_reg;
        shift_eff = shift_reg;
        left_eff  = left_reg;
        blk_eff   = blk_reg;
        part_eff  = part_reg;
        if (byte_in.start_header)
        begin
            phase_eff = bshp_pkg::PH_CLEN;
            shift_eff = '0;
            left_eff  = 3'd4;
            blk_eff   = '0;
            part_eff  = '0;
        end

        v        = {shift_eff[23:0], byte_in.header_byte};
        left_dec = (left_eff != 3'd0) ? left_eff - 3'd1 : 3'd0;
        v_zero   = (v == 32'd0);
        sum_add  = total_reg + v;

        ph_after_blocks = mode_reg[crc_bit_reg] ? bshp_pkg::PH_CRC : bshp_pkg::PH_IDLE;

        if (part_eff == bshp_pkg::PART_LAST)
        begin
            part_after_p = 2'd0;
            ph_after_p   = bshp_pkg::PH_QRAW;
        end
        else
        begin
            part_after_p = part_eff + 2'd1;
            ph_after_p   = bshp_pkg::PH_PRAW;
        end

        blk_inc = blk_eff + 8'd1;
        if (blk_inc != 8'd0 && blk_inc < blocks_reg)
            ph_after_s = bshp_pkg::PH_PRAW;
        else
            ph_after_s = ph_after_blocks;

        phase_next    = phase_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        expected_next = expected_reg;
        mode_next     = mode_reg;
        blocks_next   = blocks_reg;
        pinfo_next    = pinfo_reg;
        blk_next      = blk_reg;
        part_next     = part_reg;
        total_next    = total_reg;
        ph_nx         = bshp_pkg::PH_IDLE;

        res_valid       = 1'b0;
        res.field_kind  = phase_eff;
        res.block_index = '0;
        res.part_index  = '0;
        res.field_value = v;
        res.header_done = 1'b0;
        res.status      = 1'b0;

        if (accept)
        begin
            if (byte_in.start_header)
            begin
                phase_next = phase_eff;
                shift_next = shift_eff;
                left_next  = left_eff;
                blk_next   = blk_eff;
                part_next  = part_eff;
            end
            if (phase_eff != bshp_pkg::PH_IDLE)
            begin
                if (left_dec != 3'd0)
                begin
                    shift_next = v;
                    left_next  = left_dec;
                end
                else
                begin
                    shift_next = '0;
                    unique case (phase_eff)
                        bshp_pkg::PH_CLEN: ph_nx = bshp_pkg::PH_PLEN;
                        bshp_pkg::PH_PLEN:
                        begin
                            expected_next = v;
                            ph_nx         = bshp_pkg::PH_MODE;
                        end
                        bshp_pkg::PH_MODE:
                        begin
                            mode_next  = v[15:0];
                            total_next = '0;
                            ph_nx      = v[pack_bit_reg] ? bshp_pkg::PH_BLOCKS
                                                         : bshp_pkg::PH_TOTP;
                        end
                        bshp_pkg::PH_BLOCKS:
                        begin
                            blocks_next = v[7:0];
                            ph_nx       = bshp_pkg::PH_PINFO;
                        end
                        bshp_pkg::PH_PINFO:
                        begin
                            pinfo_next = v[7:0];
                            blk_next   = '0;
                            part_next  = '0;
                            ph_nx      = (blocks_reg != 8'd0) ? bshp_pkg::PH_PRAW
                                                              : ph_after_blocks;
                        end
                        bshp_pkg::PH_PRAW:
                        begin
                            if (!v_zero)
                            begin
                                total_next = sum_add;
                                ph_nx      = bshp_pkg::PH_PST1;
                            end
                            else
                            begin
                                part_next = part_after_p;
                                ph_nx     = ph_after_p;
                            end
                        end
                        bshp_pkg::PH_PST1:
                        begin
                            if (pinfo_reg[1])
                                ph_nx = bshp_pkg::PH_PST2;
                            else
                            begin
                                part_next = part_after_p;
                                ph_nx     = ph_after_p;
                            end
                        end
                        bshp_pkg::PH_PST2:
                        begin
                            part_next = part_after_p;
                            ph_nx     = ph_after_p;
                        end
                        bshp_pkg::PH_QRAW:
                        begin
                            if (!v_zero)
                            begin
                                total_next = sum_add;
                                ph_nx      = bshp_pkg::PH_QST1;
                            end
                            else
                                ph_nx = bshp_pkg::PH_SRAW;
                        end
                        bshp_pkg::PH_QST1:
                            ph_nx = pinfo_reg[3] ? bshp_pkg::PH_QST2 : bshp_pkg::PH_SRAW;
                        bshp_pkg::PH_QST2: ph_nx = bshp_pkg::PH_SRAW;
                        bshp_pkg::PH_SRAW:
                        begin
                            if (!v_zero)
                            begin
                                total_next = sum_add;
                                ph_nx      = bshp_pkg::PH_SST1;
                            end
                            else
                            begin
                                blk_next = blk_inc;
                                ph_nx    = ph_after_s;
                            end
                        end
                        bshp_pkg::PH_SST1:
                        begin
                            if (pinfo_reg[5])
                                ph_nx = bshp_pkg::PH_SST2;
                            else
                            begin
                                blk_next = blk_inc;
                                ph_nx    = ph_after_s;
                            end
                        end
                        bshp_pkg::PH_SST2:
                        begin
                            blk_next = blk_inc;
                            ph_nx    = ph_after_s;
                        end
                        bshp_pkg::PH_TOTP:
                        begin
                            total_next = v;
                            ph_nx      = bshp_pkg::PH_TOTQ;
                        end
                        bshp_pkg::PH_TOTQ:
                        begin
                            total_next = sum_add;
                            ph_nx      = bshp_pkg::PH_TOTS;
                        end
                        bshp_pkg::PH_TOTS:
                        begin
                            total_next = sum_add;
                            ph_nx      = ph_after_blocks;
                        end
                        default: ph_nx = bshp_pkg::PH_IDLE;
                    endcase

                    phase_next = ph_nx;
                    left_next  = bytes_for(ph_nx, pinfo_next);

                    res_valid = 1'b1;
                    if (phase_eff >= bshp_pkg::PH_PRAW && phase_eff <= bshp_pkg::PH_SST2)
                        res.block_index = blk_eff;
                    if (phase_eff >= bshp_pkg::PH_PRAW && phase_eff <= bshp_pkg::PH_PST2)
                        res.part_index = part_eff;
                    res.header_done = (ph_nx == bshp_pkg::PH_IDLE);
                    res.status      = (ph_nx == bshp_pkg::PH_IDLE)
                                      && (expected_reg != total_next);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bshp_obuf.sv -----
// two-entry output buffer: result register plus skid register
`default_nettype none

module bshp_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bshp_pkg::field_t  push_data,
    output logic                   full,
    output logic                   out_valid,
    output bshp_pkg::field_t       out_data,
    input  wire logic              out_stall
);

    logic             out_valid_reg;
    bshp_pkg::field_t out_data_reg;
    logic             skid_valid_reg;
    bshp_pkg::field_t skid_data_reg;
    logic             load_out;

    assign load_out  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/block_size_header_parser_unit.sv -----
// top level of the block size header parser
// a field is registered in the output result or skid register on its last byte
// throughput: one header byte per cycle while the output buffer is not full
// the two-entry output buffer lets bytes flow under field stall until its skid fills
// reset: parse restarts at the compressed length, sums and counters clear,
// pack mode bit resets to 0 and crc present bit to 1
`default_nettype none

module block_size_header_parser_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           byte_valid,
    output logic                                byte_stall,
    input  wire bshp_pkg::byte_t                byte_data,
    output logic                                field_valid,
    input  wire logic                           field_stall,
    output bshp_pkg::field_t                    field_data,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [bshp_pkg::CFG_WIDTH-1:0] cfg_data
);

    logic             accept;
    logic             res_valid;
    bshp_pkg::field_t res;
    logic             buf_full;

    assign byte_stall = buf_full;
    assign accept     = byte_valid && !buf_full;

    bshp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (byte_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    bshp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (field_valid),
        .out_data  (field_data),
        .out_stall (field_stall)
    );

endmodule

`default_nettype wire

// ----- hdl/bshp_checker.sv -----
// port-level checks for the block size header parser, bound to the top level
`default_nettype none

module bshp_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_stall,
    input  wire logic             field_valid,
    input  wire logic             field_stall,
    input  wire bshp_pkg::field_t field_data
);

    // stalled transaction holds
    a_field_hold: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_stall |=> field_valid && $stable(field_data))
        else $error("field transaction changed under stall");

    // skid entry only when the result register is occupied
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> field_valid)
        else $error("byte stall without a pending field");

    // format error only reported on the closing field
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_data.status |-> field_data.header_done)
        else $error("status set on a field that does not close the header");

    // partition index only on p size fields
    a_part_only_p: assert property (@(posedge clk) disable iff (!rst_n)
        field_valid && field_data.part_index != 2'd0 |->
            field_data.field_kind == 5'(bshp_pkg::PH_PRAW)
            || field_data.field_kind == 5'(bshp_pkg::PH_PST1)
            || field_data.field_kind == 5'(bshp_pkg::PH_PST2))
        else $error("part index on a field that is not a p size");

endmodule

bind block_size_header_parser_unit bshp_checker u_bshp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_stall  (byte_stall),
    .field_valid (field_valid),
    .field_stall (field_stall),
    .field_data  (field_data)
);

`default_nettype wire

// ----- test/tb_block_size_header_parser_unit.sv -----
// testbench for the block size header parser: random headers checked against a byte-level model
`timescale 1ns / 1ps

module tb_block_size_header_parser_unit;

    localparam int NUM_SETTINGS      = 6;
    localparam int ITEMS_PER_SETTING = 200;
    localparam int QUIET_LIMIT       = 2000;
    localparam int TAIL_CYCLES       = 10;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           byte_valid  = 1'b0;
    logic                           byte_stall;
    bshp_pkg::byte_t                byte_data   = '0;
    logic                           field_valid;
    logic                           field_stall = 1'b0;
    bshp_pkg::field_t               field_data;
    logic                           cfg_we      = 1'b0;
    logic                           cfg_index   = bshp_pkg::REG_PACK_MODE_BIT;
    logic [bshp_pkg::CFG_WIDTH-1:0] cfg_data    = '0;

    // parse model state, mirrors the block after reset
    logic [3:0]       pack_sel  = 4'd0;
    logic [3:0]       crc_sel   = 4'd1;
    bshp_pkg::phase_t hp_phase  = bshp_pkg::PH_CLEN;
    logic [31:0]      hp_shift  = '0;
    logic [2:0]       hp_left   = 3'd4;
    logic [31:0]      hp_plen   = '0;
    logic [15:0]      hp_mode   = '0;
    logic [7:0]       hp_blocks = '0;
    logic [7:0]       hp_pinfo  = '0;
    logic [7:0]       hp_blk    = '0;
    logic [1:0]       hp_part   = '0;
    logic [31:0]      hp_sum [3] = '{default: '0};

    bshp_pkg::byte_t  pending_bytes [$];
    bshp_pkg::field_t fields_due [$];

    int snd_idle       = 29;
    int rcv_idle       = 60;
    int items_queued   = 0;
    int bytes_sent     = 0;
    int fields_checked = 0;
    int headers_closed = 0;
    int length_errors  = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    logic [3:0] pack_choice [NUM_SETTINGS] = '{4'd0, 4'd15, 4'd0, 4'd7, 4'd15, 4'd5};
    logic [3:0] crc_choice  [NUM_SETTINGS] = '{4'd1, 4'd0, 4'd15, 4'd7, 4'd15, 4'd11};

    block_size_header_parser_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_data  (field_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bshp_pkg::phase_t close_header();
        if (hp_mode[crc_sel])
            return bshp_pkg::PH_CRC;
        return bshp_pkg::PH_IDLE;
    endfunction

    function automatic bshp_pkg::phase_t next_part();
        hp_part = hp_part + 2'd1;
        if (hp_part <= bshp_pkg::PART_LAST)
            return bshp_pkg::PH_PRAW;
        hp_part = '0;
        return bshp_pkg::PH_QRAW;
    endfunction

    function automatic bshp_pkg::phase_t next_block();
        hp_blk = hp_blk + 8'd1;
        if (hp_blk != 8'd0 && hp_blk < hp_blocks)
            return bshp_pkg::PH_PRAW;
        return close_header();
    endfunction

    function automatic void parse_byte(bshp_pkg::byte_t b);
        bshp_pkg::field_t f;
        bshp_pkg::phase_t nxt;
        logic [31:0]      v;
        if (b.start_header)
        begin
            hp_phase = bshp_pkg::PH_CLEN;
            hp_shift = '0;
            hp_left  = 3'd4;
            hp_blk   = '0;
            hp_part  = '0;
        end
        if (hp_phase == bshp_pkg::PH_IDLE)
            return;
        hp_shift = {hp_shift[23:0], b.header_byte};
        if (hp_left != 3'd0)
            hp_left = hp_left - 3'd1;
        if (hp_left != 3'd0)
            return;
        v        = hp_shift;
        hp_shift = '0;
        f        = '0;
        f.field_kind  = hp_phase;
        f.field_value = v;
        if (hp_phase >= bshp_pkg::PH_PRAW && hp_phase <= bshp_pkg::PH_SST2)
            f.block_index = hp_blk;
        if (hp_phase >= bshp_pkg::PH_PRAW && hp_phase <= bshp_pkg::PH_PST2)
            f.part_index = hp_part;
        case (hp_phase)
            bshp_pkg::PH_CLEN:   nxt = bshp_pkg::PH_PLEN;
            bshp_pkg::PH_PLEN:
            begin
                hp_plen = v;
                nxt     = bshp_pkg::PH_MODE;
            end
            bshp_pkg::PH_MODE:
            begin
                hp_mode = v[15:0];
                hp_sum  = '{default: '0};
                if (hp_mode[pack_sel])
                    nxt = bshp_pkg::PH_BLOCKS;
                else
                    nxt = bshp_pkg::PH_TOTP;
            end
            bshp_pkg::PH_BLOCKS:
            begin
                hp_blocks = v[7:0];
                nxt       = bshp_pkg::PH_PINFO;
            end
            bshp_pkg::PH_PINFO:
            begin
                hp_pinfo = v[7:0];
                hp_blk   = '0;
                hp_part  = '0;
                if (hp_blocks != 8'd0)
                    nxt = bshp_pkg::PH_PRAW;
                else
                    nxt = close_header();
            end
            bshp_pkg::PH_PRAW:
            begin
                if (v != 32'd0)
                begin
                    hp_sum[0] = hp_sum[0] + v;
                    nxt       = bshp_pkg::PH_PST1;
                end
                else
                    nxt = next_part();
            end
            bshp_pkg::PH_PST1:
            begin
                if (hp_pinfo[1])
                    nxt = bshp_pkg::PH_PST2;
                else
                    nxt = next_part();
            end
            bshp_pkg::PH_PST2:   nxt = next_part();
            bshp_pkg::PH_QRAW:
            begin
                if (v != 32'd0)
                begin
                    hp_sum[1] = hp_sum[1] + v;
                    nxt       = bshp_pkg::PH_QST1;
                end
                else
                    nxt = bshp_pkg::PH_SRAW;
            end
            bshp_pkg::PH_QST1:
            begin
                if (hp_pinfo[3])
                    nxt = bshp_pkg::PH_QST2;
                else
                    nxt = bshp_pkg::PH_SRAW;
            end
            bshp_pkg::PH_QST2:   nxt = bshp_pkg::PH_SRAW;
            bshp_pkg::PH_SRAW:
            begin
                if (v != 32'd0)
                begin
                    hp_sum[2] = hp_sum[2] + v;
                    nxt       = bshp_pkg::PH_SST1;
                end
                else
                    nxt = next_block();
            end
            bshp_pkg::PH_SST1:
            begin
                if (hp_pinfo[5])
                    nxt = bshp_pkg::PH_SST2;
                else
                    nxt = next_block();
            end
            bshp_pkg::PH_SST2:   nxt = next_block();
            bshp_pkg::PH_TOTP:
            begin
                hp_sum[0] = v;
                nxt       = bshp_pkg::PH_TOTQ;
            end
            bshp_pkg::PH_TOTQ:
            begin
                hp_sum[1] = v;
                nxt       = bshp_pkg::PH_TOTS;
            end
            bshp_pkg::PH_TOTS:
            begin
                hp_sum[2] = v;
                nxt       = close_header();
            end
            default:   nxt = bshp_pkg::PH_IDLE;
        endcase
        hp_phase = nxt;
        if (nxt == bshp_pkg::PH_MODE)
            hp_left = 3'd2;
        else if (nxt == bshp_pkg::PH_BLOCKS || nxt == bshp_pkg::PH_PINFO)
            hp_left = 3'd1;
        else if (nxt >= bshp_pkg::PH_PRAW && nxt <= bshp_pkg::PH_PST2)
            hp_left = hp_pinfo[0] ? 3'd3 : 3'd2;
        else if (nxt >= bshp_pkg::PH_QRAW && nxt <= bshp_pkg::PH_QST2)
            hp_left = hp_pinfo[2] ? 3'd3 : 3'd2;
        else if (nxt >= bshp_pkg::PH_SRAW && nxt <= bshp_pkg::PH_SST2)
            hp_left = hp_pinfo[4] ? 3'd3 : 3'd2;
        else
            hp_left = 3'd4;
        f.header_done = (nxt == bshp_pkg::PH_IDLE);
        f.status      = (nxt == bshp_pkg::PH_IDLE)
                        && (hp_plen != hp_sum[0] + hp_sum[1] + hp_sum[2]);
        fields_due.push_back(f);
    endfunction

    function automatic logic [31:0] pick_value(int n);
        logic [31:0] mask;
        mask = (n == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
        case ($urandom_range(0, 7))
            0:       return mask;
            1:       return 32'd0;
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic logic [31:0] pick_size(int n);
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0)
            return 32'd0;
        v = pick_value(n);
        return (v == 32'd0) ? 32'd1 : v;
    endfunction

    function automatic void add_field(ref logic [7:0] q [$], input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            q.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void add_noise(int n);
        bshp_pkg::byte_t nb;
        for (int i = 0; i < n; i++)
        begin
            nb.header_byte  = 8'($urandom);
            nb.start_header = 1'b0;
            pending_bytes.push_back(nb);
        end
        items_queued += n;
    endfunction

    // a cut of zero or beyond the end keeps the whole header
    function automatic void queue_header(bit blk_layout, bit with_crc, int nblk,
                                         logic [7:0] pinfo, bit len_ok, int cut);
        logic [7:0]      pre [$];
        logic [7:0]      body [$];
        logic [15:0]     mode;
        logic [31:0]     sum;
        logic [31:0]     v;
        int              n;
        bit              two;
        int              total;
        bshp_pkg::byte_t nb;
        sum  = '0;
        mode = 16'($urandom);
        mode[pack_sel] = blk_layout;
        mode[crc_sel]  = with_crc;
        blk_layout     = mode[pack_sel];
        if (blk_layout)
        begin
            add_field(body, 32'(nblk), 1);
            add_field(body, 32'(pinfo), 1);
            for (int b = 0; b < nblk; b++)
                for (int s = 0; s < 5; s++)
                begin
                    if (s < 3)
                    begin
                        n   = pinfo[0] ? 3 : 2;
                        two = pinfo[1];
                    end
                    else if (s == 3)
                    begin
                        n   = pinfo[2] ? 3 : 2;
                        two = pinfo[3];
                    end
                    else
                    begin
                        n   = pinfo[4] ? 3 : 2;
                        two = pinfo[5];
                    end
                    v = pick_size(n);
                    add_field(body, v, n);
                    sum = sum + v;
                    if (v != 32'd0)
                    begin
                        add_field(body, pick_value(n), n);
                        if (two)
                            add_field(body, pick_value(n), n);
                    end
                end
        end
        else
            for (int t = 0; t < 3; t++)
            begin
                v = pick_value(4);
                add_field(body, v, 4);
                sum = sum + v;
            end
        if (mode[crc_sel])
            add_field(body, pick_value(4), 4);
        if (!len_ok)
            sum = sum + 32'($urandom_range(1, 1000));
        add_field(pre, pick_value(4), 4);
        add_field(pre, sum, 4);
        add_field(pre, 32'(mode), 2);
        total = pre.size() + body.size();
        if (cut <= 0 || cut > total)
            cut = total;
        for (int i = 0; i < cut; i++)
        begin
            nb.header_byte  = (i < pre.size()) ? pre[i] : body[i - pre.size()];
            nb.start_header = (i == 0);
            pending_bytes.push_back(nb);
        end
        items_queued += cut;
    endfunction

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || byte_valid || fields_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(logic [3:0] pack_bit, logic [3:0] crc_bit);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bshp_pkg::REG_PACK_MODE_BIT;
        cfg_data  <= pack_bit;
        @(posedge clk);
        cfg_index <= bshp_pkg::REG_CRC_PRESENT_BIT;
        cfg_data  <= crc_bit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pack_sel = pack_bit;
        crc_sel  = crc_bit;
    endtask

    // byte channel driver, the model is advanced on every accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                parse_byte(byte_data);
                bytes_sent++;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= snd_idle)
                begin
                    byte_valid <= 1'b1;
                    byte_data  <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // field channel monitor
    always @(posedge clk or negedge rst_n)
    begin : field_monitor
        bshp_pkg::field_t want;
        if (!rst_n)
            field_stall <= 1'b0;
        else
        begin
            if (field_valid && !field_stall)
            begin
                fields_checked++;
                if (fields_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected field: kind %0d block %0d part %0d",
                                  " value %h done %b status %b"},
                                 field_data.field_kind, field_data.block_index,
                                 field_data.part_index, field_data.field_value,
                                 field_data.header_done, field_data.status);
                end
                else
                begin
                    want = fields_due.pop_front();
                    if (field_data !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"field mismatch: expected kind %0d block %0d part %0d",
                                      " value %h done %b status %b"},
                                     want.field_kind, want.block_index, want.part_index,
                                     want.field_value, want.header_done, want.status);
                            $display({"                got      kind %0d block %0d part %0d",
                                      " value %h done %b status %b"},
                                     field_data.field_kind, field_data.block_index,
                                     field_data.part_index, field_data.field_value,
                                     field_data.header_done, field_data.status);
                        end
                    end
                    else if (want.header_done)
                    begin
                        headers_closed++;
                        if (want.status)
                            length_errors++;
                    end
                end
            end
            field_stall <= ($urandom_range(0, 99) < rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (field_valid && !field_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int budget;
        int roll;
        int nblk;
        int cut;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            if (s != 0)
            begin
                wait_idle();
                apply_setting(pack_choice[s], crc_choice[s]);
            end
            snd_idle = (s < 2) ? 29 : (s < 4) ? 60 : 0;
            rcv_idle = (s < 2) ? 60 : (s < 4) ? 29 : 0;
            if (s == 0)
            begin
                // zero block count with pack-info closing the header
                queue_header(1'b1, 1'b0, 0, 8'hFF, 1'b1, 0);
                // trailing bytes with no restart are ignored
                add_noise(2);
                // full block count, abandoned by a restart part way through
                queue_header(1'b1, 1'b0, 255, 8'h00, 1'b1, 18);
                // zero block count followed by a crc, length mismatch
                queue_header(1'b1, 1'b1, 0, 8'hC0, 1'b0, 0);
            end
            budget = items_queued + ITEMS_PER_SETTING;
            while (items_queued < budget)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    add_noise($urandom_range(1, 3));
                else
                begin
                    nblk = $urandom_range(0, 99);
                    nblk = (nblk < 10) ? 0 : (nblk < 95) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 12);
                    cut  = (roll < 22) ? $urandom_range(1, 40) : 0;
                    queue_header(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), nblk,
                                 8'($urandom), $urandom_range(0, 99) < 70, cut);
                end
            end
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d header bytes over %0d register settings, %0d fields checked",
                 bytes_sent, NUM_SETTINGS, fields_checked);
        $display("%0d headers completed, %0d of them with a length mismatch, %0d mismatches",
                 headers_closed, length_errors, mismatches);
        if (mismatches == 0 && fields_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
